/* sv/can_message_segmenter_tx_queue_core_macros.svh */
// Assertion macros for the CAN message segmenter transmit queue.
`ifndef CAN_MESSAGE_SEGMENTER_TX_QUEUE_CORE_MACROS_SVH
`define CAN_MESSAGE_SEGMENTER_TX_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CMSTQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmstq: assertion failed");

// next-cycle implication
`define CMSTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cmstq: assertion failed");

`else

`define CMSTQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CMSTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* sv/cmstq_pkg.sv */
// Shared types, codes and helpers for the CAN message segmenter transmit queue.
package cmstq_pkg;

    localparam int ID_W   = 29;
    localparam int DLC_W  = 4;
    localparam int DATA_W = 64;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_XMIT = 1'b1
    } cmstq_op_t;

    typedef enum logic [1:0] {
        MARK_NONE   = 2'd0,
        MARK_FIRST  = 2'd1,
        MARK_MIDDLE = 2'd2,
        MARK_FINAL  = 2'd3
    } cmstq_mark_t;

    typedef struct packed {
        cmstq_op_t  operation;
        logic [7:0] data_byte;
        logic [7:0] msg_len;
        logic [4:0] func_type;
        logic [6:0] dest_id;
        logic       mailbox_free;
    } cmstq_item_t;

    typedef struct packed {
        logic [ID_W-1:0]   ext_id;
        logic [DLC_W-1:0]  dlc;
        logic [DATA_W-1:0] data;
    } cmstq_frame_t;

    typedef struct packed {
        logic         valid;
        cmstq_frame_t frame;
    } cmstq_push_t;

    typedef struct packed {
        logic frame_valid;
        logic dropped;
    } cmstq_qstat_t;

    function automatic logic [ID_W-1:0] pack_id(
        input logic [6:0]  stn,
        input logic [4:0]  fn,
        input logic [7:0]  seg,
        input cmstq_mark_t mk,
        input logic [6:0]  dst
    );
        return {dst, mk, seg, fn, stn};
    endfunction

endpackage

/* sv/cmstq_if.sv */
// Handshake channel interfaces: input item, result item and configuration write.
interface cmstq_item_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;
    logic [7:0] msg_len;
    logic [4:0] func_type;
    logic [6:0] dest_id;
    logic       mailbox_free;

    modport source (
        output valid, operation, data_byte, msg_len, func_type, dest_id, mailbox_free,
        input  ready
    );
    modport sink (
        input  valid, operation, data_byte, msg_len, func_type, dest_id, mailbox_free,
        output ready
    );
endinterface

interface cmstq_result_if;
    logic        valid;
    logic        ready;
    logic        frame_valid;
    logic [28:0] ext_id;
    logic [3:0]  dlc;
    logic [63:0] frame_data;
    logic        dropped;

    modport source (
        output valid, frame_valid, ext_id, dlc, frame_data, dropped,
        input  ready
    );
    modport sink (
        input  valid, frame_valid, ext_id, dlc, frame_data, dropped,
        output ready
    );
endinterface

interface cmstq_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] station_id;

    modport source (
        output valid, station_id,
        input  ready
    );
    modport sink (
        input  valid, station_id,
        output ready
    );
endinterface

/* sv/cmstq_seg.sv */
// Frame assembly: gathers message bytes into chunks and builds the extended ID.
module cmstq_seg
    import cmstq_pkg::*;
#(
    parameter int CHUNK_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  cmstq_item_t item,
    input  logic [6:0]  station_id,
    output cmstq_push_t push
);

    localparam int PW = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam int AW = CHUNK_BYTES * 8;
    localparam logic [PW-1:0] POS_LAST = PW'(CHUNK_BYTES - 1);
    localparam logic [7:0]    LEN_ONE  = 8'(CHUNK_BYTES);

    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    off_reg, off_next;
    logic [7:0]    seg_reg, seg_next;
    logic [AW-1:0] asm_reg, asm_next;

    logic [8:0]    newoff;
    logic          last;
    logic          close;
    logic [AW-1:0] asm_cur;
    cmstq_mark_t   mark;

    always_comb
    begin
        newoff = {1'b0, off_reg} + 9'd1;
        last   = newoff >= {1'b0, item.msg_len};
        close  = last || (pos_reg == POS_LAST);
        for (int i = 0; i < CHUNK_BYTES; i++)
        begin
            if (pos_reg == PW'(i))
                asm_cur[8*i +: 8] = item.data_byte;
            else if (pos_reg == '0)
                asm_cur[8*i +: 8] = 8'h00;
            else
                asm_cur[8*i +: 8] = asm_reg[8*i +: 8];
        end
        if (item.msg_len <= LEN_ONE)
            mark = MARK_NONE;
        else if (last)
            mark = MARK_FINAL;
        else if (seg_reg == 8'd0)
            mark = MARK_FIRST;
        else
            mark = MARK_MIDDLE;
    end

    always_comb
    begin
        pos_next = pos_reg;
        off_next = off_reg;
        seg_next = seg_reg;
        asm_next = asm_reg;
        push     = '0;
        if (step)
        begin
            if (item.msg_len == 8'd0)
            begin
                // empty message: one empty NONE frame, drop any partial message
                push.valid        = 1'b1;
                push.frame.ext_id = pack_id(station_id, item.func_type, 8'd0,
                                            MARK_NONE, item.dest_id);
                pos_next = '0;
                off_next = '0;
                seg_next = '0;
                asm_next = '0;
            end
            else if (close)
            begin
                push.valid        = 1'b1;
                push.frame.ext_id = pack_id(station_id, item.func_type, seg_reg,
                                            mark, item.dest_id);
                push.frame.dlc    = 4'(pos_reg) + 4'd1;
                push.frame.data   = 64'(asm_cur);
                asm_next = '0;
                pos_next = '0;
                if (last)
                begin
                    off_next = '0;
                    seg_next = '0;
                end
                else
                begin
                    off_next = newoff[7:0];
                    seg_next = seg_reg + 8'd1;
                end
            end
            else
            begin
                asm_next = asm_cur;
                pos_next = pos_reg + 1'b1;
                off_next = newoff[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            off_reg <= '0;
            seg_reg <= '0;
            asm_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            off_reg <= off_next;
            seg_reg <= seg_next;
            asm_reg <= asm_next;
        end
    end

endmodule

/* sv/cmstq_queue.sv */
// Ring frame queue: one push and one pop per cycle, registered read data.
module cmstq_queue
    import cmstq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 128
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  cmstq_push_t  push,
    input  logic         pop_req,
    output cmstq_qstat_t stat,
    output cmstq_frame_t head
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [AW-1:0] IDX_LAST = AW'(QUEUE_DEPTH - 1);

    cmstq_frame_t mem [QUEUE_DEPTH];

    logic [AW-1:0] rd_reg, rd_next;
    logic [AW-1:0] wr_reg, wr_next;
    cmstq_qstat_t  stat_reg, stat_next;
    cmstq_frame_t  head_reg;

    logic [AW-1:0] rd_inc, wr_inc;
    logic          full, empty, do_push, do_pop;

    always_comb
    begin
        rd_inc  = (rd_reg == IDX_LAST) ? '0 : rd_reg + 1'b1;
        wr_inc  = (wr_reg == IDX_LAST) ? '0 : wr_reg + 1'b1;
        empty   = rd_reg == wr_reg;
        full    = wr_inc == rd_reg;
        do_push = push.valid && !full;
        do_pop  = pop_req && !empty;
        rd_next = do_pop ? rd_inc : rd_reg;
        wr_next = do_push ? wr_inc : wr_reg;
        stat_next.frame_valid = do_pop;
        stat_next.dropped     = push.valid && full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg   <= '0;
            wr_reg   <= '0;
            stat_reg <= '0;
        end
        else
        begin
            rd_reg <= rd_next;
            wr_reg <= wr_next;
            if (adv)
                stat_reg <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_inc] <= push.frame;
        if (adv)
            head_reg <= mem[rd_inc];
    end

    assign stat = stat_reg;
    assign head = head_reg;

endmodule

/* sv/can_message_segmenter_tx_queue_core.sv */
// Top level of the CAN message segmenter with transmit frame queue.
// One item (message byte or transmit attempt) is accepted every clock unless
// the result channel stalls; each gives one result through an input register,
// then assembly and the queue memory, then the result register. Back-pressure
// on the result channel stalls both stages, but an empty input register still
// takes an item while a result waits. The queue holds QUEUE_DEPTH-1 frames
// and needs no clearing pass after reset. station_id is taken whenever the
// configuration channel is valid and is used when a frame is completed.
`include "can_message_segmenter_tx_queue_core_macros.svh"

module can_message_segmenter_tx_queue_core
    import cmstq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 128,
    parameter int CHUNK_BYTES = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    cmstq_item_if.sink            item,
    cmstq_result_if.source        result,
    cmstq_cfg_if.sink             cfg
);

    cmstq_item_t  item_reg;
    logic         iv_reg, iv_next;
    logic         ov_reg, ov_next;
    logic [6:0]   station_reg;

    logic         adv, step, accept;
    cmstq_push_t  push;
    cmstq_qstat_t stat;
    cmstq_frame_t head;

    assign adv        = !ov_reg || result.ready;
    assign step       = adv && iv_reg;
    assign item.ready = !iv_reg || adv;
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        iv_next = iv_reg;
        if (accept)
            iv_next = 1'b1;
        else if (adv)
            iv_next = 1'b0;
        ov_next = adv ? iv_reg : ov_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg      <= 1'b0;
            ov_reg      <= 1'b0;
            station_reg <= '0;
        end
        else
        begin
            iv_reg <= iv_next;
            ov_reg <= ov_next;
            if (cfg.valid)
                station_reg <= cfg.station_id;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.operation    <= cmstq_op_t'(item.operation);
            item_reg.data_byte    <= item.data_byte;
            item_reg.msg_len      <= item.msg_len;
            item_reg.func_type    <= item.func_type;
            item_reg.dest_id      <= item.dest_id;
            item_reg.mailbox_free <= item.mailbox_free;
        end
    end

    cmstq_seg #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_seg (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step && (item_reg.operation == OP_BYTE)),
        .item       (item_reg),
        .station_id (station_reg),
        .push       (push)
    );

    cmstq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .push    (push),
        .pop_req (step && (item_reg.operation == OP_XMIT) && item_reg.mailbox_free),
        .stat    (stat),
        .head    (head)
    );

    // frame fields read as zero when nothing was sent
    assign result.valid       = ov_reg;
    assign result.frame_valid = stat.frame_valid;
    assign result.dropped     = stat.dropped;
    assign result.ext_id      = stat.frame_valid ? head.ext_id : '0;
    assign result.dlc         = stat.frame_valid ? head.dlc : '0;
    assign result.frame_data  = stat.frame_valid ? head.data : '0;

    `CMSTQ_ASSERT_IMPL(a_pop_xor_drop, clk, rst_n, ov_reg, !(stat.frame_valid && stat.dropped))
    `CMSTQ_ASSERT_NEXT(a_step_gives_result, clk, rst_n, step, ov_reg)
    `CMSTQ_ASSERT_IMPL(a_stall_only_full, clk, rst_n, !item.ready, iv_reg && ov_reg)
    `CMSTQ_ASSERT_IMPL(a_dlc_bound, clk, rst_n, ov_reg && stat.frame_valid, head.dlc <= 4'(CHUNK_BYTES))

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the CAN message segmenter transmit queue.
module tb_top;
    import cmstq_pkg::*;

    localparam int QDEPTH       = 128;
    localparam int STALL_LIMIT  = 3000;
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        logic        frame_valid;
        logic [28:0] ext_id;
        logic [3:0]  dlc;
        logic [63:0] data;
        logic        dropped;
    } tx_result_t;

    logic clk;
    logic rst_n;

    cmstq_item_if   item_bus();
    cmstq_result_if result_bus();
    cmstq_cfg_if    cfg_bus();

    can_message_segmenter_tx_queue_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // predictor copy of the block state
    logic [28:0] q_id   [QDEPTH];
    logic [3:0]  q_dlc  [QDEPTH];
    logic [63:0] q_data [QDEPTH];
    logic [6:0]  rd_idx;
    logic [6:0]  wr_idx;
    logic [63:0] asm_bytes;
    logic [7:0]  msg_off;
    logic [7:0]  seg_cnt;
    logic [6:0]  station;

    cmstq_item_t pending_items [$];
    tx_result_t  expected_tx [$];
    cmstq_item_t offered;
    bit          drv_live;
    bit          quiet;
    bit          long_hold;
    bit          hold_done;
    int          src_gap;
    int          sink_gap;
    int          hold_cnt;
    int          stall_cycles;
    int          n_queued;
    int          n_accepted;
    int          n_frames_sent;
    int          n_drops;
    int          n_cfg_writes;
    int          n_errors;

    function automatic logic push_frame(input logic [28:0] id, input logic [3:0] dlc,
                                        input logic [63:0] data);
        logic [6:0] nxt;
        nxt = wr_idx + 7'd1;
        if (nxt == rd_idx)
        begin
            n_drops++;
            return 1'b1;
        end
        wr_idx       = nxt;
        q_id[nxt]    = id;
        q_dlc[nxt]   = dlc;
        q_data[nxt]  = data;
        return 1'b0;
    endfunction

    // Expected outcome of one accepted transaction; updates the queue copy.
    function automatic tx_result_t segment_and_queue(input cmstq_item_t it);
        tx_result_t  r;
        logic [2:0]  pos;
        logic [8:0]  next_off;
        logic        last;
        cmstq_mark_t mark;
        r = '0;
        if (it.operation == OP_XMIT)
        begin
            if (rd_idx != wr_idx && it.mailbox_free)
            begin
                rd_idx        = rd_idx + 7'd1;
                r.frame_valid = 1'b1;
                r.ext_id      = q_id[rd_idx];
                r.dlc         = q_dlc[rd_idx];
                r.data        = q_data[rd_idx];
                n_frames_sent++;
            end
        end
        else if (it.msg_len == 8'd0)
        begin
            // empty frame now; any partial message is thrown away
            r.dropped = push_frame({it.dest_id, MARK_NONE, 8'd0, it.func_type, station},
                                   4'd0, 64'd0);
            asm_bytes = '0;
            msg_off   = '0;
            seg_cnt   = '0;
        end
        else
        begin
            pos      = msg_off[2:0];
            next_off = {1'b0, msg_off} + 9'd1;
            if (pos == 3'd0)
                asm_bytes = '0;
            asm_bytes[8*pos +: 8] = it.data_byte;
            last = next_off >= {1'b0, it.msg_len};
            if (last || pos == 3'd7)
            begin
                if (it.msg_len <= 8'd8)
                    mark = MARK_NONE;
                else if (last)
                    mark = MARK_FINAL;
                else if (seg_cnt == 8'd0)
                    mark = MARK_FIRST;
                else
                    mark = MARK_MIDDLE;
                r.dropped = push_frame({it.dest_id, mark, seg_cnt, it.func_type, station},
                                       {1'b0, pos} + 4'd1, asm_bytes);
                asm_bytes = '0;
                if (last)
                begin
                    msg_off = '0;
                    seg_cnt = '0;
                end
                else
                begin
                    msg_off = next_off[7:0];
                    seg_cnt = seg_cnt + 8'd1;
                end
            end
            else
                msg_off = next_off[7:0];
        end
        return r;
    endfunction

    function automatic void add_item(input cmstq_op_t op, input logic [7:0] d,
                                     input logic [7:0] len, input logic [4:0] fn,
                                     input logic [6:0] dst, input logic mb);
        cmstq_item_t it;
        it.operation    = op;
        it.data_byte    = d;
        it.msg_len      = len;
        it.func_type    = fn;
        it.dest_id      = dst;
        it.mailbox_free = mb;
        pending_items.push_back(it);
        n_queued++;
    endfunction

    function automatic void add_xmit(input logic mb);
        add_item(OP_XMIT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)), mb);
    endfunction

    function automatic logic [7:0] pick_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 10)
            return 8'd0;
        else if (p < 60)
            return 8'($urandom_range(1, 8));
        else if (p < 90)
            return 8'($urandom_range(9, 40));
        else if (p < 97)
            return 8'($urandom_range(41, 254));
        return 8'd255;
    endfunction

    // One message; a broken one switches msg_len partway through. A message
    // still open when the item budget runs out is left unfinished.
    function automatic void gen_message(input int xmit_pct, input bit broken,
                                        input int stop_at);
        logic [7:0] len;
        logic [4:0] fn;
        logic [6:0] dst;
        int         cut;
        len = pick_len();
        fn  = 5'($urandom_range(0, 31));
        dst = 7'($urandom_range(0, 127));
        cut = broken ? $urandom_range(0, len) : -1;
        if (len == 8'd0)
        begin
            add_item(OP_BYTE, 8'($urandom_range(0, 255)), 8'd0, fn, dst,
                     1'($urandom_range(0, 1)));
            return;
        end
        for (int i = 0; i < len; i++)
        begin
            if (n_queued >= stop_at)
                return;
            if (i == cut)
            begin
                add_item(OP_BYTE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         fn, dst, 1'($urandom_range(0, 1)));
                return;
            end
            add_item(OP_BYTE, 8'($urandom_range(0, 255)), len, fn, dst,
                     1'($urandom_range(0, 1)));
            if ($urandom_range(0, 99) < xmit_pct)
                add_xmit($urandom_range(0, 9) != 0);
        end
    endfunction

    function automatic void gen_traffic(input int target, input int xmit_pct);
        int start;
        int p;
        start = n_queued;
        while (n_queued - start < target)
        begin
            p = $urandom_range(0, 99);
            if (p < 85)
                gen_message(xmit_pct, 1'b0, start + target);
            else if (p < 95)
                gen_message(xmit_pct, 1'b1, start + target);
            else
                add_item(cmstq_op_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                         7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
        end
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || drv_live || expected_tx.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_station(input logic [6:0] v);
        @(posedge clk);
        cfg_bus.valid      <= 1'b1;
        cfg_bus.station_id <= v;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        station = v;
        n_cfg_writes++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_bus.valid && item_bus.ready)
            begin
                expected_tx.push_back(segment_and_queue(offered));
                n_accepted++;
                drv_live = 1'b0;
            end
            if (!drv_live)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (pending_items.size() != 0)
                begin
                    offered                = pending_items.pop_front();
                    item_bus.operation    <= offered.operation;
                    item_bus.data_byte    <= offered.data_byte;
                    item_bus.msg_len      <= offered.msg_len;
                    item_bus.func_type    <= offered.func_type;
                    item_bus.dest_id      <= offered.dest_id;
                    item_bus.mailbox_free <= offered.mailbox_free;
                    drv_live               = 1'b1;
                    if (!quiet && $urandom_range(0, 15) == 0)
                        src_gap = $urandom_range(1, 10);
                end
            end
            item_bus.valid <= drv_live;
        end
    end

    // monitor and result checker
    always @(posedge clk)
    begin
        tx_result_t got;
        tx_result_t want;
        logic       rdy;
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                got.frame_valid = result_bus.frame_valid;
                got.ext_id      = result_bus.ext_id;
                got.dlc         = result_bus.dlc;
                got.data        = result_bus.frame_data;
                got.dropped     = result_bus.dropped;
                if (expected_tx.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: result transaction with nothing expected: %p", got);
                end
                else
                begin
                    want = expected_tx.pop_front();
                    if (got !== want)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display({"ERROR: mismatch exp fv=%0b id=%h dlc=%0d data=%h drop=%0b",
                                      " got fv=%0b id=%h dlc=%0d data=%h drop=%0b"},
                                     want.frame_valid, want.ext_id, want.dlc, want.data,
                                     want.dropped, got.frame_valid, got.ext_id, got.dlc,
                                     got.data, got.dropped);
                    end
                end
            end
            if (long_hold && !hold_done)
            begin
                hold_cnt  = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                rdy = 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                rdy = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
                if (!quiet && $urandom_range(0, 11) == 0)
                    sink_gap = $urandom_range(1, 10);
            end
            result_bus.ready <= rdy;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (item_bus.valid && item_bus.ready) ||
            (result_bus.valid && result_bus.ready) || (cfg_bus.valid && cfg_bus.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     stall_cycles, expected_tx.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        logic [6:0] stations [5];
        rst_n                 = 1'b0;
        item_bus.valid        = 1'b0;
        item_bus.operation    = OP_BYTE;
        item_bus.data_byte    = '0;
        item_bus.msg_len      = '0;
        item_bus.func_type    = '0;
        item_bus.dest_id      = '0;
        item_bus.mailbox_free = 1'b0;
        result_bus.ready      = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.station_id    = '0;
        rd_idx    = '0;
        wr_idx    = '0;
        asm_bytes = '0;
        msg_off   = '0;
        seg_cnt   = '0;
        station   = '0;
        for (int i = 0; i < QDEPTH; i++)
        begin
            q_id[i]   = '0;
            q_dlc[i]  = '0;
            q_data[i] = '0;
        end
        drv_live = 0; quiet = 0; long_hold = 0; hold_done = 0;
        src_gap = 0; sink_gap = 0; hold_cnt = 0; stall_cycles = 0;
        n_queued = 0; n_accepted = 0; n_frames_sent = 0; n_drops = 0;
        n_cfg_writes = 0; n_errors = 0;
        stations[0] = 7'd127;
        stations[1] = 7'd0;
        stations[2] = 7'h55;
        stations[3] = 7'($urandom_range(0, 127));
        stations[4] = 7'h2A;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty queue, zero length, no mailbox, short/long messages,
        // zero length aborting a partial message, length shrinking mid-message
        add_item(OP_XMIT, 8'hFF, 8'hFF, 5'd31, 7'd127, 1'b1);
        add_item(OP_BYTE, 8'hFF, 8'd0, 5'd31, 7'd127, 1'b0);
        add_item(OP_XMIT, 8'h00, 8'h00, 5'd0, 7'd0, 1'b0);
        add_item(OP_XMIT, 8'h00, 8'h00, 5'd0, 7'd0, 1'b1);
        add_item(OP_BYTE, 8'h00, 8'd1, 5'd0, 7'd0, 1'b1);
        for (int i = 0; i < 9; i++)
            add_item(OP_BYTE, 8'hFF - 8'(i), 8'd9, 5'h15, 7'h2A, 1'b0);
        add_item(OP_BYTE, 8'h11, 8'd5, 5'd3, 7'd4, 1'b1);
        add_item(OP_BYTE, 8'h22, 8'd5, 5'd3, 7'd4, 1'b1);
        add_item(OP_BYTE, 8'h33, 8'd0, 5'd3, 7'd4, 1'b1);
        add_item(OP_BYTE, 8'hA5, 8'd20, 5'd9, 7'd64, 1'b0);
        add_item(OP_BYTE, 8'h5A, 8'd20, 5'd9, 7'd64, 1'b0);
        add_item(OP_BYTE, 8'hC3, 8'd1, 5'd9, 7'd64, 1'b0);
        for (int i = 0; i < 5; i++)
            add_item(OP_XMIT, 8'h00, 8'h00, 5'd0, 7'd0, 1'b1);
        wait_idle();

        for (int p = 0; p < 5; p++)
        begin
            write_station(stations[p]);
            case (p)
                0:
                begin
                    gen_traffic(130, 30);
                    long_hold = 1'b1;
                end
                1:
                begin
                    // overfill the frame queue, then drain it past empty
                    for (int i = 0; i < 140; i++)
                        add_item(OP_BYTE, 8'($urandom_range(0, 255)), 8'd0,
                                 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)),
                                 1'($urandom_range(0, 1)));
                    gen_traffic(20, 0);
                    for (int i = 0; i < 145; i++)
                        add_xmit($urandom_range(0, 7) != 0);
                end
                2:
                begin
                    gen_traffic(65, 30);
                    wait_idle();
                    gen_traffic(65, 30);
                end
                3:
                    gen_traffic(130, 15);
                default:
                begin
                    quiet = 1'b1;
                    gen_traffic(100, 30);
                    for (int i = 0; i < 30; i++)
                        add_xmit(1'b1);
                end
            endcase
            wait_idle();
        end

        repeat (10) @(posedge clk);
        $display("run: %0d transactions in, %0d frames sent, %0d frames dropped on full queue",
                 n_accepted, n_frames_sent, n_drops);
        $display("run: %0d station writes, long result stall and idle pauses, %0d mismatches",
                 n_cfg_writes, n_errors);
        if (n_errors == 0 && expected_tx.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
